// ===== rtl/cmn_pkg.sv =====
// Shared types, constants and helpers for the crop / mirror / normalize block.
// Used by cmn_cfg_regs and crop_mirror_normalize_pixels_top; no dependencies.
package cmn_pkg;

    // Largest image or window dimension handled
    localparam int MAX_DIM   = 1024;
    localparam int DIM_W     = $clog2(MAX_DIM) + 1;   // holds MAX_DIM itself
    localparam int COORD_W   = $clog2(MAX_DIM);       // row / column index
    localparam int PLANE_W   = 2 * COORD_W + 1;       // window area, up to MAX_DIM^2
    localparam int STRIDE_W  = DIM_W + 1;             // window width times channels
    localparam int OFFSET_W  = 22;

    localparam int POS_W     = 17;
    localparam logic [POS_W-1:0] POS_ONE = 17'h10000;

    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;

    // Pipeline depth of the datapath
    localparam int NSTG = 6;

    // Register file indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CROP_POS_ROW  = 3'd0,
        REG_CROP_POS_COL  = 3'd1,
        REG_WINDOW_HEIGHT = 3'd2,
        REG_WINDOW_WIDTH  = 3'd3,
        REG_COLOR_MODE    = 3'd4,
        REG_PLANAR_LAYOUT = 3'd5,
        REG_MEAN_WORDS    = 3'd6,
        REG_INV_STD_WORDS = 3'd7
    } cfg_index_t;

    // Reset values
    localparam logic [POS_W-1:0]      RST_CROP_POS   = 17'd32768;
    localparam logic [DIM_W-1:0]      RST_WINDOW_DIM = 11'd224;
    localparam logic [CFG_DATA_W-1:0] RST_MEAN_WORDS = 48'h0;
    localparam logic [CFG_DATA_W-1:0] RST_INV_WORDS  = 48'h1000_1000_1000;

    // Channel codes
    localparam logic [1:0] CH_0 = 2'd0;
    localparam logic [1:0] CH_1 = 2'd1;
    localparam logic [1:0] CH_2 = 2'd2;

    // Derived configuration seen by the datapath
    typedef struct packed {
        logic [DIM_W-1:0]    wh;        // clamped window height
        logic [DIM_W-1:0]    ww;        // clamped window width
        logic [POS_W-1:0]    pos_row;   // clamped to 1.0
        logic [POS_W-1:0]    pos_col;
        logic                three;     // three channels
        logic                planar;    // CHW order
        logic [CFG_DATA_W-1:0] mean_words;
        logic [CFG_DATA_W-1:0] inv_words;
        logic [PLANE_W-1:0]  plane;     // wh * ww
        logic [STRIDE_W-1:0] stride;    // row stride of the offset
    } cfg_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] lim;
        lim = DIM_W'(MAX_DIM);
        return (v > lim) ? lim : v;
    endfunction

endpackage

// ===== rtl/crop_mirror_normalize_pixels_top.sv =====
// Crop / mirror / normalize of one interleaved image element per transfer.
// Depends on cmn_pkg and cmn_cfg_regs.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+------------------------------------------------
//  input   | in_valid/in_stall  | pixel_value row col channel image_height
//          |                    | image_width mirror
//  output  | out_valid/out_stall| elem_offset norm_value fault
//  config  | cfg_we             | cfg_index cfg_data (write only)
//
// Six register stages: input capture, clamp/subtract, multiply, window test
// and rounding, offset products, offset sum into the output register.
// One element per cycle while the output is not stalled.
// Elements outside the window or with an unused channel leave as bubbles.
// Reset clears the stage valid bits and restores the register defaults.
// out_stall holds a full stage only while all later stages are full; empty stages still fill.
module crop_mirror_normalize_pixels_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cmn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cmn_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     pixel_value,
    input  logic [9:0]                     row,
    input  logic [9:0]                     col,
    input  logic [1:0]                     channel,
    input  logic [10:0]                    image_height,
    input  logic [10:0]                    image_width,
    input  logic                           mirror,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [21:0]                    elem_offset,
    output logic signed [15:0]             norm_value,
    output logic                           fault
);
    import cmn_pkg::*;

    cfg_t cfg;

    cmn_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stage valid bits and advance enables
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;
    logic [NSTG-1:0] adv;

    // Stage 0: captured inputs
    logic [7:0]         s0_pix_reg;
    logic [COORD_W-1:0] s0_row_reg, s0_col_reg;
    logic [1:0]         s0_ch_reg;
    logic [DIM_W-1:0]   s0_ih_reg, s0_iw_reg;
    logic               s0_mir_reg;

    // Stage 1: clamps, slack, mean subtract
    logic               s1_fault_reg, s1_fault_next;
    logic               s1_chok_reg, s1_chok_next;
    logic [DIM_W-1:0]   s1_slr_reg, s1_slr_next;
    logic [DIM_W-1:0]   s1_slc_reg, s1_slc_next;
    logic signed [16:0] s1_d_reg, s1_d_next;
    logic [15:0]        s1_inv_reg, s1_inv_next;
    logic [1:0]         s1_ch_reg;
    logic [COORD_W-1:0] s1_row_reg, s1_col_reg;
    logic               s1_mir_reg;
    logic [OFFSET_W-1:0] s1_chp_reg, s1_chp_next;
    logic [15:0]        mean_sel;
    logic [DIM_W-1:0]   ih_c, iw_c;

    // Stage 2: products
    logic [DIM_W-1:0]   s2_oy_reg, s2_oy_next;
    logic [DIM_W-1:0]   s2_ox_reg, s2_ox_next;
    logic signed [32:0] s2_p_reg, s2_p_next;
    logic               s2_fault_reg, s2_chok_reg, s2_mir_reg;
    logic [1:0]         s2_ch_reg;
    logic [COORD_W-1:0] s2_row_reg, s2_col_reg;
    logic [OFFSET_W-1:0] s2_chp_reg;
    logic [DIM_W+POS_W-1:0] oy_prod, ox_prod;
    logic signed [33:0] p_prod;

    // Stage 3: window test, mirror, rounding
    logic               s3_fault_reg;
    logic [COORD_W-1:0] s3_oh_reg, s3_oh_next;
    logic [COORD_W-1:0] s3_ow_reg, s3_ow_next;
    logic signed [15:0] s3_q_reg, s3_q_next;
    logic [1:0]         s3_ch_reg;
    logic [OFFSET_W-1:0] s3_chp_reg;
    logic               keep;
    logic [DIM_W:0]     rr, cc;
    logic [DIM_W-1:0]   owm;
    logic signed [33:0] rnd;
    logic signed [33:0] shq;

    // Stage 4: offset terms
    logic               s4_fault_reg;
    logic signed [15:0] s4_q_reg;
    logic [OFFSET_W-1:0] s4_rowt_reg, s4_rowt_next;
    logic [OFFSET_W-1:0] s4_base_reg, s4_base_next;

    // Stage 5: output register
    logic               s5_fault_reg;
    logic signed [15:0] s5_q_reg;
    logic [OFFSET_W-1:0] s5_off_reg, s5_off_next;

    // Advance chain: a stage moves when empty or when its successor moves
    always_comb
    begin
        adv[NSTG-1] = !v_reg[NSTG-1] || !out_stall;
        for (int k = NSTG - 2; k >= 0; k--)
            adv[k] = !v_reg[k] || adv[k+1];
    end

    assign in_stall = !adv[0];

    always_comb
    begin
        v_next[0] = in_valid;
        v_next[1] = v_reg[0];
        v_next[2] = v_reg[1];
        v_next[3] = v_reg[2] && keep;
        v_next[4] = v_reg[3];
        v_next[5] = v_reg[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int k = 0; k < NSTG; k++)
                if (adv[k])
                    v_reg[k] <= v_next[k];
        end
    end

    // Stage 1 logic: clamp, size check, slack, mean subtract, channel plane
    always_comb
    begin
        ih_c = clamp_dim(s0_ih_reg);
        iw_c = clamp_dim(s0_iw_reg);
        s1_fault_next = (ih_c < cfg.wh) || (iw_c < cfg.ww);
        s1_chok_next  = cfg.three ? (s0_ch_reg != 2'd3) : (s0_ch_reg == CH_0);
        s1_slr_next   = ih_c - cfg.wh;
        s1_slc_next   = iw_c - cfg.ww;
        unique case (s0_ch_reg)
            CH_0:
            begin
                mean_sel    = cfg.mean_words[15:0];
                s1_inv_next = cfg.inv_words[15:0];
                s1_chp_next = '0;
            end
            CH_1:
            begin
                mean_sel    = cfg.mean_words[31:16];
                s1_inv_next = cfg.inv_words[31:16];
                s1_chp_next = {1'b0, cfg.plane};
            end
            CH_2:
            begin
                mean_sel    = cfg.mean_words[47:32];
                s1_inv_next = cfg.inv_words[47:32];
                s1_chp_next = {cfg.plane, 1'b0};
            end
            default:
            begin
                mean_sel    = '0;
                s1_inv_next = '0;
                s1_chp_next = '0;
            end
        endcase
        s1_d_next = $signed({1'b0, s0_pix_reg, 8'h00}) - $signed({1'b0, mean_sel});
    end

    // Stage 2 logic: crop origins and scaling product
    always_comb
    begin
        oy_prod    = {{POS_W{1'b0}}, s1_slr_reg} * {{DIM_W{1'b0}}, cfg.pos_row};
        ox_prod    = {{POS_W{1'b0}}, s1_slc_reg} * {{DIM_W{1'b0}}, cfg.pos_col};
        s2_oy_next = oy_prod[16 +: DIM_W];
        s2_ox_next = ox_prod[16 +: DIM_W];
        p_prod     = 34'(s1_d_reg) * 34'($signed({1'b0, s1_inv_reg}));
        s2_p_next  = p_prod[32:0];
    end

    // Stage 3 logic: window test, output row/column, round and saturate
    always_comb
    begin
        rr = {2'b00, s2_row_reg} - {1'b0, s2_oy_reg};
        cc = {2'b00, s2_col_reg} - {1'b0, s2_ox_reg};
        keep = s2_fault_reg ||
               (s2_chok_reg && !rr[DIM_W] && (rr[DIM_W-1:0] < cfg.wh) &&
                !cc[DIM_W] && (cc[DIM_W-1:0] < cfg.ww));
        s3_oh_next = rr[COORD_W-1:0];
        owm = cfg.ww - DIM_W'(1) - cc[DIM_W-1:0];
        s3_ow_next = s2_mir_reg ? owm[COORD_W-1:0] : cc[COORD_W-1:0];
        // nearest, ties toward plus infinity: floor((p + 2048) / 4096)
        rnd = {s2_p_reg[32], s2_p_reg} + 34'sd2048;
        shq = rnd >>> 12;
        priority if (shq > 34'sd32767)
            s3_q_next = 16'sh7FFF;
        else if (shq < -34'sd32768)
            s3_q_next = -16'sh8000;
        else
            s3_q_next = shq[15:0];
    end

    // Stage 4 logic: row term and column/channel base
    always_comb
    begin
        s4_rowt_next = {{(OFFSET_W-COORD_W){1'b0}}, s3_oh_reg} *
                       {{(OFFSET_W-STRIDE_W){1'b0}}, cfg.stride};
        if (cfg.planar)
            s4_base_next = s3_chp_reg + {{(OFFSET_W-COORD_W){1'b0}}, s3_ow_reg};
        else if (cfg.three)
            s4_base_next = {{(OFFSET_W-COORD_W-1){1'b0}}, s3_ow_reg, 1'b0}
                         + {{(OFFSET_W-COORD_W){1'b0}}, s3_ow_reg}
                         + {{(OFFSET_W-2){1'b0}}, s3_ch_reg};
        else
            s4_base_next = {{(OFFSET_W-COORD_W){1'b0}}, s3_ow_reg}
                         + {{(OFFSET_W-2){1'b0}}, s3_ch_reg};
    end

    // Stage 5 logic: final offset, wraps to the port width
    assign s5_off_next = s4_rowt_reg + s4_base_reg;

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s0_pix_reg <= pixel_value;
            s0_row_reg <= row;
            s0_col_reg <= col;
            s0_ch_reg  <= channel;
            s0_ih_reg  <= image_height;
            s0_iw_reg  <= image_width;
            s0_mir_reg <= mirror;
        end
        if (adv[1])
        begin
            s1_fault_reg <= s1_fault_next;
            s1_chok_reg  <= s1_chok_next;
            s1_slr_reg   <= s1_slr_next;
            s1_slc_reg   <= s1_slc_next;
            s1_d_reg     <= s1_d_next;
            s1_inv_reg   <= s1_inv_next;
            s1_ch_reg    <= s0_ch_reg;
            s1_row_reg   <= s0_row_reg;
            s1_col_reg   <= s0_col_reg;
            s1_mir_reg   <= s0_mir_reg;
            s1_chp_reg   <= s1_chp_next;
        end
        if (adv[2])
        begin
            s2_oy_reg    <= s2_oy_next;
            s2_ox_reg    <= s2_ox_next;
            s2_p_reg     <= s2_p_next;
            s2_fault_reg <= s1_fault_reg;
            s2_chok_reg  <= s1_chok_reg;
            s2_mir_reg   <= s1_mir_reg;
            s2_ch_reg    <= s1_ch_reg;
            s2_row_reg   <= s1_row_reg;
            s2_col_reg   <= s1_col_reg;
            s2_chp_reg   <= s1_chp_reg;
        end
        if (adv[3])
        begin
            s3_fault_reg <= s2_fault_reg;
            s3_oh_reg    <= s3_oh_next;
            s3_ow_reg    <= s3_ow_next;
            s3_q_reg     <= s3_q_next;
            s3_ch_reg    <= s2_ch_reg;
            s3_chp_reg   <= s2_chp_reg;
        end
        if (adv[4])
        begin
            s4_fault_reg <= s3_fault_reg;
            s4_q_reg     <= s3_q_reg;
            s4_rowt_reg  <= s4_rowt_next;
            s4_base_reg  <= s4_base_next;
        end
        if (adv[5])
        begin
            s5_fault_reg <= s4_fault_reg;
            s5_q_reg     <= s4_q_reg;
            s5_off_reg   <= s5_off_next;
        end
    end

    // Output ports; a size fault forces offset and value to zero
    assign out_valid   = v_reg[NSTG-1];
    assign fault       = s5_fault_reg;
    assign elem_offset = s5_fault_reg ? '0 : s5_off_reg;
    assign norm_value  = s5_fault_reg ? '0 : s5_q_reg;

    // Assertions
    a_stall_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_stall && out_valid))
        else $error("input stalled without a stalled output");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fault) |-> (elem_offset == '0 && norm_value == '0))
        else $error("fault result carries nonzero payload");

    a_offset_in_image: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !fault) |->
            ({2'b00, elem_offset} < ({3'b000, cfg.plane} +
             (cfg.three ? {2'b00, cfg.plane, 1'b0} : 24'd0))))
        else $error("offset beyond the output image");

    a_drop_only_at_window: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[2] && s2_fault_reg && adv[3]) |=> v_reg[3])
        else $error("size fault element dropped");

endmodule

// ===== rtl/cmn_cfg_regs.sv =====
// Configuration register file for crop / mirror / normalize, plus the
// derived values (clamped sizes, window area, row stride). Depends on cmn_pkg.
module cmn_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cmn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cmn_pkg::CFG_DATA_W-1:0] cfg_data,
    output cmn_pkg::cfg_t                 cfg
);
    import cmn_pkg::*;

    logic [POS_W-1:0]      pos_row_reg;
    logic [POS_W-1:0]      pos_col_reg;
    logic [DIM_W-1:0]      wh_reg;
    logic [DIM_W-1:0]      ww_reg;
    logic                  color_reg;
    logic                  planar_reg;
    logic [CFG_DATA_W-1:0] mean_reg;
    logic [CFG_DATA_W-1:0] inv_reg;

    logic [DIM_W-1:0]      wh_c;
    logic [DIM_W-1:0]      ww_c;
    logic [2*DIM_W-1:0]    area;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_row_reg <= RST_CROP_POS;
            pos_col_reg <= RST_CROP_POS;
            wh_reg      <= RST_WINDOW_DIM;
            ww_reg      <= RST_WINDOW_DIM;
            color_reg   <= 1'b1;
            planar_reg  <= 1'b1;
            mean_reg    <= RST_MEAN_WORDS;
            inv_reg     <= RST_INV_WORDS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_CROP_POS_ROW:  pos_row_reg <= cfg_data[POS_W-1:0];
                REG_CROP_POS_COL:  pos_col_reg <= cfg_data[POS_W-1:0];
                REG_WINDOW_HEIGHT: wh_reg      <= cfg_data[DIM_W-1:0];
                REG_WINDOW_WIDTH:  ww_reg      <= cfg_data[DIM_W-1:0];
                REG_COLOR_MODE:    color_reg   <= cfg_data[0];
                REG_PLANAR_LAYOUT: planar_reg  <= cfg_data[0];
                REG_MEAN_WORDS:    mean_reg    <= cfg_data;
                REG_INV_STD_WORDS: inv_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Derived values; combinational from the registers, so later transfers see them
    always_comb
    begin
        wh_c = clamp_dim(wh_reg);
        ww_c = clamp_dim(ww_reg);
        area = {{DIM_W{1'b0}}, wh_c} * {{DIM_W{1'b0}}, ww_c};

        cfg.wh         = wh_c;
        cfg.ww         = ww_c;
        cfg.pos_row    = (pos_row_reg > POS_ONE) ? POS_ONE : pos_row_reg;
        cfg.pos_col    = (pos_col_reg > POS_ONE) ? POS_ONE : pos_col_reg;
        cfg.three      = color_reg;
        cfg.planar     = planar_reg;
        cfg.mean_words = mean_reg;
        cfg.inv_words  = inv_reg;
        cfg.plane      = area[PLANE_W-1:0];
        // planar: stride is the width; interleaved: width times channel count
        if (planar_reg || !color_reg)
            cfg.stride = {1'b0, ww_c};
        else
            cfg.stride = {ww_c, 1'b0} + {1'b0, ww_c};
    end

endmodule
